@@ hdl/oscillating_servo_drive_defines.svh @@
// Assertion macros used by the checker file of the servo drive.
`ifndef OSCILLATING_SERVO_DRIVE_DEFINES_SVH
`define OSCILLATING_SERVO_DRIVE_DEFINES_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define OSD_ASSERT_SAME(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("osd assertion failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define OSD_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("osd assertion failed");

`endif

@@ hdl/osd_pkg.sv @@
// Package with the shared types, constants and sine generator of the servo drive.
package osd_pkg;

  localparam int TICKS_PER_TURN  = 1024;
  localparam int TPT_W           = $clog2(TICKS_PER_TURN);
  localparam int SINE_DEPTH_DFLT = 1024;

  localparam int TIME_W   = 32;
  localparam int ENC_W    = 10;
  localparam int DRIVE_W  = 10;
  localparam int TARGET_W = 11;
  localparam int SINE_W   = 16;
  localparam int IN_W     = 48;
  localparam int OUT_W    = 24;
  localparam int CFG_A_W  = 3;
  localparam int CFG_D_W  = 32;

  localparam logic [8:0] DRIVE_LIMIT_RST = 9'd63;

  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [CFG_A_W-1:0] {
    REG_PHASE_STEP   = 3'd0,
    REG_AMPLITUDE    = 3'd1,
    REG_PHASE_SHIFT  = 3'd2,
    REG_CENTER_POS   = 3'd3,
    REG_MECH_ZERO    = 3'd4,
    REG_REV_ROTATION = 3'd5,
    REG_REV_SENSING  = 3'd6,
    REG_DRIVE_LIMIT  = 3'd7
  } osd_reg_e;

  typedef struct packed {
    logic [31:0]        phase_step;
    logic [10:0]        amplitude;
    logic [9:0]         phase_shift;
    logic signed [9:0]  center_pos;
    logic [9:0]         mech_zero;
    logic               reverse_rotation;
    logic               reverse_sensing;
    logic [8:0]         drive_limit;
  } osd_cfg_t;

  // Register values after reset.
  localparam osd_cfg_t CFG_RST = '{
    phase_step:       32'd0,
    amplitude:        11'd0,
    phase_shift:      10'd0,
    center_pos:       10'sd0,
    mech_zero:        10'd0,
    reverse_rotation: 1'b0,
    reverse_sensing:  1'b0,
    drive_limit:      DRIVE_LIMIT_RST
  };

  // Q1.15 sine of a 32-bit turn angle, by a Q30 Taylor series to x^11.
  // Only evaluated at elaboration to fill the sine ROM.
  function automatic logic signed [SINE_W-1:0] sine_q15(input logic [31:0] ang);
    logic [1:0]  quad;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] q;
    quad = ang[31:30];
    r    = {34'd0, ang[29:0]};
    if (quad[0]) begin
      r = Q30_ONE - r;
    end
    x  = (r * HALF_PI_Q30) >> 30;
    x2 = (x * x) >> 30;
    t  = Q30_ONE - x2 / 64'd110;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
    s  = (x * t) >> 30;
    q  = (s * 64'd32767 + 64'd536870912) >> 30;
    if (q > 64'd32767) begin
      q = 64'd32767;
    end
    return quad[1] ? -signed'(q[SINE_W-1:0]) : signed'(q[SINE_W-1:0]);
  endfunction

endpackage

@@ hdl/osd_phase.sv @@
// Phase accumulation stages: time times frequency, offset add and sine index.
module osd_phase import osd_pkg::*; #(
  parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DFLT,
  parameter int IDX_W            = $clog2(SINE_TABLE_DEPTH)
) (
  input  logic                clk_i,
  input  logic [1:0]          en_i,
  input  osd_cfg_t            cfg_i,
  input  logic [TIME_W-1:0]   time_ms_i,
  output logic [IDX_W-1:0]    idx_o
);

  localparam int DEP_W = $clog2(SINE_TABLE_DEPTH + 1);
  localparam logic [DEP_W-1:0] DEPTH_C = DEP_W'(SINE_TABLE_DEPTH);

  logic [31:0]         prod_q, prod_d;
  logic [31:0]         phase;
  logic [32+DEP_W-1:0] scaled;
  logic [IDX_W-1:0]    idx_q, idx_d;

  // Only the low 32 bits of the product matter: the phase wraps per turn.
  assign prod_d = 32'(time_ms_i * cfg_i.phase_step);

  assign phase  = prod_q + (32'(cfg_i.phase_shift) << (32 - TPT_W));
  assign scaled = (32+DEP_W)'(phase) * (32+DEP_W)'(DEPTH_C);
  assign idx_d  = scaled[32 +: IDX_W];

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      prod_q <= prod_d;
    end
    if (en_i[1]) begin
      idx_q <= idx_d;
    end
  end

  assign idx_o = idx_q;

endmodule

@@ hdl/osd_sine_rom.sv @@
// Sine lookup ROM with registered read data.
module osd_sine_rom import osd_pkg::*; #(
  parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DFLT,
  parameter int IDX_W            = $clog2(SINE_TABLE_DEPTH)
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [IDX_W-1:0]         idx_i,
  output logic signed [SINE_W-1:0] sine_o
);

  typedef logic signed [SINE_W-1:0] rom_t [SINE_TABLE_DEPTH];

  function automatic rom_t build_rom();
    rom_t        rom;
    logic [63:0] ang;
    for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
      ang    = (64'(i) << 32) / SINE_TABLE_DEPTH;
      rom[i] = sine_q15(ang[31:0]);
    end
    return rom;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  logic signed [SINE_W-1:0] sine_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sine_q <= SINE_ROM[idx_i];
    end
  end

  assign sine_o = sine_q;

endmodule

@@ hdl/osd_target.sv @@
// Target stages: scale the sine, add the center, apply direction and zero, reduce.
module osd_target import osd_pkg::*; (
  input  logic                       clk_i,
  input  logic [1:0]                 en_i,
  input  osd_cfg_t                   cfg_i,
  input  logic signed [SINE_W-1:0]   sine_i,
  output logic signed [TARGET_W-1:0] target_o
);

  localparam int PROD_W = 27;
  localparam int V_W    = 29;

  logic signed [PROD_W-1:0]   prod_q, prod_d;
  logic signed [V_W-1:0]      v_sum, v_dir, v_fin;
  logic [V_W-1:0]             v_mag;
  logic [V_W-1:0]             t_mag;
  logic signed [TARGET_W-1:0] rem_s;
  logic signed [TARGET_W-1:0] target_q, target_d;

  assign prod_d = signed'({1'b0, cfg_i.amplitude[10:1]}) * sine_i;

  assign v_sum = (V_W'(cfg_i.center_pos) <<< 15) + V_W'(prod_q);
  assign v_dir = cfg_i.reverse_rotation ? -v_sum : v_sum;
  assign v_fin = v_dir - (signed'(V_W'(cfg_i.mech_zero)) <<< 15);

  // Truncate toward zero, then take the remainder with the sign of the value.
  assign v_mag    = v_fin[V_W-1] ? V_W'(-v_fin) : V_W'(v_fin);
  assign t_mag    = v_mag >> 15;
  assign rem_s    = signed'({1'b0, t_mag[TPT_W-1:0]});
  assign target_d = v_fin[V_W-1] ? -rem_s : rem_s;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      prod_q <= prod_d;
    end
    if (en_i[1]) begin
      target_q <= target_d;
    end
  end

  assign target_o = target_q;

endmodule

@@ hdl/osd_error.sv @@
// Output stage: shortest-path error against the reading and drive saturation.
module osd_error import osd_pkg::*; (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  osd_cfg_t                   cfg_i,
  input  logic signed [TARGET_W-1:0] target_i,
  input  logic [ENC_W-1:0]           reading_i,
  output logic signed [DRIVE_W-1:0]  drive_o,
  output logic signed [TARGET_W-1:0] target_o
);

  localparam int DIFF_W = TARGET_W + 1;

  logic signed [DIFF_W-1:0]   rd_pos, rd_s, diff;
  logic signed [DRIVE_W-1:0]  err, lim, drive_d;
  logic signed [DRIVE_W-1:0]  drive_q;
  logic signed [TARGET_W-1:0] target_q;

  assign rd_pos = signed'(DIFF_W'(reading_i));
  assign rd_s   = cfg_i.reverse_sensing ? -rd_pos : rd_pos;
  assign diff   = DIFF_W'(target_i) - rd_s;

  // The wrapped error is the value in -512..511 congruent to the difference,
  // which is just its low bits read as signed.
  assign err = signed'(diff[TPT_W-1:0]);
  assign lim = signed'({1'b0, cfg_i.drive_limit});

  always_comb begin
    drive_d = err;
    if (err > lim) begin
      drive_d = lim;
    end
    if (err < -lim) begin
      drive_d = -lim;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      drive_q  <= drive_d;
      target_q <= target_i;
    end
  end

  assign drive_o  = drive_q;
  assign target_o = target_q;

endmodule

@@ hdl/oscillating_servo_drive.sv @@
// Top level of the oscillating servo drive: config registers, pipeline control, stages.
//
//   Channel   Direction  Handshake              Contents
//   s_axis    in         tvalid/tready          tdata: time_ms[31:0], encoder_reading[41:32]
//   m_axis    out        tvalid/tready          tdata: drive[9:0], target_position[20:10]
//   cfg       in         cfg_we_i (no wait)     cfg_addr_i register index, cfg_data_i value
//
// Six register stages: phase product, phase add and index, sine ROM read,
// amplitude product, target reduction, and the error and drive output register.
// A result passes the stages in the order above once its item is taken. While no stage
// is held by back-pressure, one item can enter and each advances one stage every cycle.
// Reset clears the stage valid bits and loads the register defaults (drive limit
// 63, all others zero). A stage loads when empty or when its item moves on.
module oscillating_servo_drive import osd_pkg::*; #(
  parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DFLT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Input items.
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [IN_W-1:0]    s_axis_tdata,   // time_ms[31:0], encoder_reading[41:32], zeros
  // Result items.
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [OUT_W-1:0]   m_axis_tdata,   // drive[9:0], target_position[20:10], zeros
  // Configuration writes.
  input  logic               cfg_we_i,
  input  logic [CFG_A_W-1:0] cfg_addr_i,
  input  logic [CFG_D_W-1:0] cfg_data_i
);

  localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);
  localparam int NS    = 6;

  osd_cfg_t cfg_q;

  logic [NS-1:0]   vld_q;
  logic [NS-1:0]   en;
  logic [ENC_W-1:0] rd_q [NS-1];

  logic [IDX_W-1:0]           idx;
  logic signed [SINE_W-1:0]   sine;
  logic signed [TARGET_W-1:0] target_mid;
  logic signed [TARGET_W-1:0] target_out;
  logic signed [DRIVE_W-1:0]  drive;

  // Configuration registers. Writes are expected only while the pipeline is
  // idle, since all stages but the sine ROM read them directly.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RST;
    end else if (cfg_we_i) begin
      case (osd_reg_e'(cfg_addr_i))
        REG_PHASE_STEP:   cfg_q.phase_step       <= cfg_data_i;
        REG_AMPLITUDE:    cfg_q.amplitude        <= cfg_data_i[10:0];
        REG_PHASE_SHIFT:  cfg_q.phase_shift      <= cfg_data_i[9:0];
        REG_CENTER_POS:   cfg_q.center_pos       <= signed'(cfg_data_i[9:0]);
        REG_MECH_ZERO:    cfg_q.mech_zero        <= cfg_data_i[9:0];
        REG_REV_ROTATION: cfg_q.reverse_rotation <= cfg_data_i[0];
        REG_REV_SENSING:  cfg_q.reverse_sensing  <= cfg_data_i[0];
        REG_DRIVE_LIMIT:  cfg_q.drive_limit      <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  // Stage enables ripple back from the output: a stage may load when it is
  // empty or when its current item moves on.
  always_comb begin
    en[NS-1] = !vld_q[NS-1] || m_axis_tready;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !vld_q[i] || en[i+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= s_axis_tvalid;
      end
      for (int i = 1; i < NS; i++) begin
        if (en[i]) begin
          vld_q[i] <= vld_q[i-1];
        end
      end
    end
  end

  // The encoder reading rides alongside until the output stage needs it.
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      rd_q[0] <= s_axis_tdata[TIME_W +: ENC_W];
    end
    for (int i = 1; i < NS - 1; i++) begin
      if (en[i]) begin
        rd_q[i] <= rd_q[i-1];
      end
    end
  end

  osd_phase #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
    .IDX_W            (IDX_W)
  ) u_phase (
    .clk_i     (clk_i),
    .en_i      (en[1:0]),
    .cfg_i     (cfg_q),
    .time_ms_i (s_axis_tdata[TIME_W-1:0]),
    .idx_o     (idx)
  );

  osd_sine_rom #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
    .IDX_W            (IDX_W)
  ) u_rom (
    .clk_i  (clk_i),
    .en_i   (en[2]),
    .idx_i  (idx),
    .sine_o (sine)
  );

  osd_target u_target (
    .clk_i    (clk_i),
    .en_i     (en[4:3]),
    .cfg_i    (cfg_q),
    .sine_i   (sine),
    .target_o (target_mid)
  );

  osd_error u_error (
    .clk_i     (clk_i),
    .en_i      (en[5]),
    .cfg_i     (cfg_q),
    .target_i  (target_mid),
    .reading_i (rd_q[NS-2]),
    .drive_o   (drive),
    .target_o  (target_out)
  );

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = vld_q[NS-1];
  assign m_axis_tdata  = {3'd0, target_out, drive};

endmodule

@@ hdl/osd_checker.sv @@
// Port-level checker for the servo drive and its bind to the top level.
`include "oscillating_servo_drive_defines.svh"

module osd_checker import osd_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata
);

  // A result held under back-pressure stays put.
  `OSD_ASSERT_NEXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // The drive is clamped to at most 511 in magnitude, so -512 never shows.
  `OSD_ASSERT_SAME(a_drive_rng, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[9:0] != 10'h200)

  // The target is a remainder by one turn, so -1024 never shows.
  `OSD_ASSERT_SAME(a_tgt_rng, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[20:10] != 11'h400)

  // With the output register empty, every stage can move, so input is taken.
  `OSD_ASSERT_SAME(a_ready, clk_i, rst_ni, !m_axis_tvalid, s_axis_tready)

endmodule

bind oscillating_servo_drive osd_checker u_osd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

@@ dv/tb.sv @@
// Self-checking testbench for the oscillating servo drive, with its own drive predictor.
`timescale 1ns / 1ps

module tb import osd_pkg::*; ();

  // The run is stopped and failed if it goes past this many clock cycles.
  localparam int unsigned CYCLE_LIMIT = 400000;
  // Clock edges that pass after the last result before a register is
  // written, and after the end of the stimulus.
  localparam int SETTLE_CYCLES = 10;
  localparam int RAND_PHASES = 7;
  localparam int PHASE_ITEMS = 200;
  // Denominators of the Horner steps of the sine series, innermost first.
  localparam int unsigned HORNER_DIV [5] = '{110, 72, 42, 20, 6};

  typedef struct packed {
    logic signed [DRIVE_W-1:0]  drive;
    logic signed [TARGET_W-1:0] target;
  } servo_cmd_t;

  typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_e;

  typedef struct {
    row_kind_e                  kind;
    osd_reg_e                   idx;
    logic [CFG_D_W-1:0]         value;
    logic [TIME_W-1:0]          t_ms;
    logic [ENC_W-1:0]           enc;
    logic                       typed;
    logic signed [DRIVE_W-1:0]  drive;
    logic signed [TARGET_W-1:0] target;
  } stim_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [IN_W-1:0]    s_axis_tdata = '0;   // time_ms[31:0], encoder_reading[41:32], zeros
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [OUT_W-1:0]   m_axis_tdata;        // drive[9:0], target_position[20:10], zeros
  logic               cfg_we = 1'b0;
  logic [CFG_A_W-1:0] cfg_addr = '0;
  logic [CFG_D_W-1:0] cfg_data = '0;

  // Register copies that the predictor works from, at their reset values.
  logic [31:0]       cfg_phase_step = '0;
  logic [10:0]       cfg_amplitude = '0;
  logic [9:0]        cfg_phase_shift = '0;
  logic signed [9:0] cfg_zero_dir = '0;
  logic [9:0]        cfg_cal_zero = '0;
  logic              cfg_rev_rot = 1'b0;
  logic              cfg_rev_sense = 1'b0;
  logic [8:0]        cfg_drive_limit = DRIVE_LIMIT_RST;

  servo_cmd_t  pending_cmds [$];
  stim_row_t   stim_table [$];
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;
  logic        gaps_on = 1'b1;

  logic [TIME_W-1:0]  clock_ms;
  logic [ENC_W-1:0]   enc_val;
  logic [CFG_D_W-1:0] reg_mask;
  logic [CFG_D_W-1:0] reg_low;
  logic [CFG_D_W-1:0] reg_val;
  osd_reg_e           reg_idx;

  oscillating_servo_drive u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we),
    .cfg_addr_i    (cfg_addr),
    .cfg_data_i    (cfg_data)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Q1.15 sine of table index k. The index names a 32-bit turn angle whose
  // top two bits give the quadrant; the first-quadrant angle is scaled to
  // radians in Q30 and run through a truncating Horner series up to x^11.
  function automatic int sine_at(input logic [9:0] k);
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] h;
    logic [63:0] s;
    logic [63:0] q;
    r = {34'd0, k[7:0], 22'd0};
    if (k[8]) begin
      r = 64'd1073741824 - r;
    end
    x  = (r * 64'd1686629713) >> 30;
    x2 = (x * x) >> 30;
    h  = 64'd1073741824;
    for (int i = 0; i < 5; i++) begin
      h = 64'd1073741824 - ((x2 * h) >> 30) / 64'(HORNER_DIV[i]);
    end
    s = (x * h) >> 30;
    q = (s * 64'd32767 + 64'd536870912) >> 30;
    if (q > 64'd32767) begin
      q = 64'd32767;
    end
    return k[9] ? -int'(q) : int'(q);
  endfunction

  // Drive command and target for one control tick under the current
  // register copies.
  function automatic servo_cmd_t predict_cmd(input logic [TIME_W-1:0] t_ms,
                                             input logic [ENC_W-1:0] enc);
    logic [31:0] phase;
    longint      pos;
    longint      tgt;
    longint      rd;
    longint      err;
    longint      lim;
    servo_cmd_t  cmd;
    phase = t_ms * cfg_phase_step + {cfg_phase_shift, 22'd0};
    pos = longint'(cfg_zero_dir) * 32768
        + longint'(cfg_amplitude >> 1) * longint'(sine_at(phase[31:22]));
    if (cfg_rev_rot) begin
      pos = -pos;
    end
    pos = pos - longint'(cfg_cal_zero) * 32768;
    // Signed division truncates toward zero and the remainder keeps the
    // sign of the dividend, as the block requires.
    tgt = (pos / 32768) % 1024;
    rd = longint'(enc);
    if (cfg_rev_sense) begin
      rd = -rd;
    end
    // Wrap the error onto the shortest way round, then clamp it.
    err = (tgt - rd) % 1024;
    if (err > 511) begin
      err = err - 1024;
    end
    if (err < -512) begin
      err = err + 1024;
    end
    lim = longint'(cfg_drive_limit);
    if (err > lim) begin
      err = lim;
    end
    if (err < -lim) begin
      err = -lim;
    end
    cmd.drive  = err[DRIVE_W-1:0];
    cmd.target = tgt[TARGET_W-1:0];
    return cmd;
  endfunction

  function automatic stim_row_t tick_row(input logic [TIME_W-1:0] t_ms,
                                         input logic [ENC_W-1:0] enc);
    stim_row_t row;
    row = '{ROW_TICK, REG_PHASE_STEP, '0, t_ms, enc, 1'b0, '0, '0};
    return row;
  endfunction

  function automatic stim_row_t typed_row(input logic [TIME_W-1:0] t_ms,
                                          input logic [ENC_W-1:0] enc,
                                          input logic signed [DRIVE_W-1:0] drv,
                                          input logic signed [TARGET_W-1:0] tgt);
    stim_row_t row;
    row = '{ROW_TICK, REG_PHASE_STEP, '0, t_ms, enc, 1'b1, drv, tgt};
    return row;
  endfunction

  function automatic stim_row_t write_row(input osd_reg_e idx,
                                          input logic [CFG_D_W-1:0] value);
    stim_row_t row;
    row = '{ROW_WRITE, idx, value, '0, '0, 1'b0, '0, '0};
    return row;
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 100) begin
      $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
    end
  endtask

  // Writes one register and mirrors the write into the predictor's copy.
  // The enable drops for a cycle afterwards, so back-to-back calls never
  // schedule two values onto it in the same step.
  task automatic write_reg(input osd_reg_e idx, input logic [CFG_D_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= value;
    @(posedge clk_i);
    case (idx)
      REG_PHASE_STEP:   cfg_phase_step  = value[31:0];
      REG_AMPLITUDE:    cfg_amplitude   = value[10:0];
      REG_PHASE_SHIFT:  cfg_phase_shift = value[9:0];
      REG_CENTER_POS:   cfg_zero_dir    = value[9:0];
      REG_MECH_ZERO:    cfg_cal_zero    = value[9:0];
      REG_REV_ROTATION: cfg_rev_rot     = value[0];
      REG_REV_SENSING:  cfg_rev_sense   = value[0];
      REG_DRIVE_LIMIT:  cfg_drive_limit = value[8:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  // Stops sending, lets every outstanding result come back, and then lets
  // the pipeline run empty.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_cmds.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Offers one tick, with random gaps in front of it unless gaps are off, and
  // records what it should produce once the block has taken it.
  task automatic push_tick(input logic [TIME_W-1:0] t_ms, input logic [ENC_W-1:0] enc,
                           input logic typed, input logic signed [DRIVE_W-1:0] drv,
                           input logic signed [TARGET_W-1:0] tgt);
    servo_cmd_t want;
    while (gaps_on && $urandom_range(99) < 19) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_W - TIME_W - ENC_W){1'b0}}, enc, t_ms};
    @(posedge clk_i);
    while (!s_axis_tready) begin
      @(posedge clk_i);
    end
    if (typed) begin
      want.drive  = drv;
      want.target = tgt;
    end else begin
      want = predict_cmd(t_ms, enc);
    end
    pending_cmds.push_back(want);
  endtask

  // Result side: every accepted item is checked against the oldest pending
  // command, and the ready line idles at random unless gaps are off.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end else if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_cmds.size() == 0) begin
          flag_mismatch($sformatf("result with nothing pending, data %h", m_axis_tdata));
        end else begin
          if (m_axis_tdata[9:0] !== pending_cmds[0].drive) begin
            flag_mismatch($sformatf("drive %0d, expected %0d",
                                    $signed(m_axis_tdata[9:0]),
                                    pending_cmds[0].drive));
          end
          if (m_axis_tdata[20:10] !== pending_cmds[0].target) begin
            flag_mismatch($sformatf("target %0d, expected %0d",
                                    $signed(m_axis_tdata[20:10]),
                                    pending_cmds[0].target));
          end
          void'(pending_cmds.pop_front());
        end
      end
      m_axis_tready <= !(gaps_on && $urandom_range(99) < 19);
    end
  end

  initial begin
    // Directed part. Right after reset the amplitude is zero, so the target
    // is plain register arithmetic and the expected commands are typed in.
    stim_table.push_back(typed_row(32'd0, 10'd0, 10'sd0, 11'sd0));
    stim_table.push_back(typed_row(32'hFFFF_FFFF, 10'd1023, 10'sd1, 11'sd0));
    stim_table.push_back(typed_row(32'd12345, 10'd512, -10'sd63, 11'sd0));
    stim_table.push_back(typed_row(32'd7, 10'd513, 10'sd63, 11'sd0));
    stim_table.push_back(write_row(REG_DRIVE_LIMIT, 32'd511));
    stim_table.push_back(typed_row(32'd0, 10'd513, 10'sd511, 11'sd0));
    stim_table.push_back(typed_row(32'd0, 10'd512, -10'sd511, 11'sd0));
    stim_table.push_back(write_row(REG_CENTER_POS, 32'h0000_01FF));
    stim_table.push_back(typed_row(32'd0, 10'd0, 10'sd511, 11'sd511));
    // Only the low ten bits count, so this lands on the most negative centre.
    stim_table.push_back(write_row(REG_CENTER_POS, 32'hFFFF_FE00));
    stim_table.push_back(typed_row(32'd0, 10'd0, -10'sd511, -11'sd512));
    stim_table.push_back(typed_row(32'd0, 10'd1023, -10'sd511, -11'sd512));
    stim_table.push_back(write_row(REG_REV_SENSING, 32'd1));
    stim_table.push_back(typed_row(32'd0, 10'd1023, 10'sd511, -11'sd512));
    stim_table.push_back(write_row(REG_REV_ROTATION, 32'd1));
    stim_table.push_back(typed_row(32'd0, 10'd1023, 10'sd511, 11'sd512));
    // An error of exactly half a turn wraps to the negative side.
    stim_table.push_back(write_row(REG_MECH_ZERO, 32'd1023));
    stim_table.push_back(typed_row(32'd0, 10'd1023, -10'sd511, -11'sd511));
    stim_table.push_back(write_row(REG_DRIVE_LIMIT, 32'd0));
    stim_table.push_back(typed_row(32'd0, 10'd5, 10'sd0, -11'sd511));
    stim_table.push_back(write_row(REG_REV_ROTATION, 32'd0));
    stim_table.push_back(write_row(REG_CENTER_POS, 32'd0));
    stim_table.push_back(write_row(REG_REV_SENSING, 32'd0));
    stim_table.push_back(write_row(REG_DRIVE_LIMIT, 32'h0000_01FF));
    stim_table.push_back(typed_row(32'd0, 10'd0, 10'sd1, -11'sd1023));
    // From here on the sine is live; an odd amplitude drops its low bit.
    stim_table.push_back(write_row(REG_MECH_ZERO, 32'd0));
    stim_table.push_back(write_row(REG_AMPLITUDE, 32'd2047));
    stim_table.push_back(write_row(REG_PHASE_SHIFT, 32'd256));
    stim_table.push_back(tick_row(32'd0, 10'd0));
    stim_table.push_back(tick_row(32'd0, 10'd700));
    stim_table.push_back(write_row(REG_PHASE_SHIFT, 32'd1023));
    stim_table.push_back(tick_row(32'd0, 10'd1023));
    stim_table.push_back(write_row(REG_PHASE_STEP, 32'hFFFF_FFFF));
    stim_table.push_back(tick_row(32'hFFFF_FFFF, 10'd0));
    stim_table.push_back(tick_row(32'd1, 10'd300));
    stim_table.push_back(write_row(REG_PHASE_STEP, 32'h0040_0000));
    stim_table.push_back(write_row(REG_PHASE_SHIFT, 32'd0));
    stim_table.push_back(tick_row(32'd0, 10'd17));
    stim_table.push_back(tick_row(32'd256, 10'd512));
    stim_table.push_back(tick_row(32'd512, 10'd1000));
    stim_table.push_back(tick_row(32'd768, 10'd255));
    stim_table.push_back(write_row(REG_REV_ROTATION, 32'd1));
    stim_table.push_back(write_row(REG_REV_SENSING, 32'd1));
    stim_table.push_back(tick_row(32'd100, 10'd10));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_table[i]) begin
      if (stim_table[i].kind == ROW_WRITE) begin
        settle();
        write_reg(stim_table[i].idx, stim_table[i].value);
      end else begin
        push_tick(stim_table[i].t_ms, stim_table[i].enc, stim_table[i].typed,
                  stim_table[i].drive, stim_table[i].target);
      end
    end

    // Random part. Each phase rewrites every register, often at one of its
    // extremes and with junk above the register's width, then runs ticks
    // whose time mostly counts forward like a real millisecond clock.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      settle();
      for (int r = 0; r < 8; r++) begin
        reg_idx = osd_reg_e'(r);
        case (reg_idx)
          REG_PHASE_STEP:                        reg_mask = 32'hFFFF_FFFF;
          REG_AMPLITUDE:                         reg_mask = 32'h0000_07FF;
          REG_REV_ROTATION, REG_REV_SENSING:     reg_mask = 32'h0000_0001;
          REG_DRIVE_LIMIT:                       reg_mask = 32'h0000_01FF;
          default:                               reg_mask = 32'h0000_03FF;
        endcase
        // The signed centre has its extremes at the two middle codes.
        reg_low = (reg_idx == REG_CENTER_POS) ? 32'h200 : 32'h0;
        case ($urandom_range(3))
          0:       reg_val = reg_low;
          1:       reg_val = (reg_idx == REG_CENTER_POS) ? 32'h1FF : reg_mask;
          default: reg_val = $urandom();
        endcase
        write_reg(reg_idx, ($urandom() & ~reg_mask) | (reg_val & reg_mask));
      end
      // One phase runs with both sides at full rate.
      gaps_on  = (ph != 3);
      clock_ms = $urandom();
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Once, the sender holds off until every result is back.
        if (ph == 1 && n == PHASE_ITEMS / 2) begin
          settle();
        end
        if ($urandom_range(3) != 0) begin
          clock_ms = clock_ms + $urandom_range(1, 3);
        end else begin
          clock_ms = $urandom();
        end
        case ($urandom_range(7))
          0:       enc_val = 10'd0;
          1:       enc_val = 10'd1023;
          default: enc_val = $urandom_range(1023);
        endcase
        push_tick(clock_ms, enc_val, 1'b0, '0, '0);
      end
    end

    settle();
    if (mismatch_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
